// ----- sv/prg_pkg.sv -----
// Shared types, codes and helpers for the PIN retry counter guard.
// No dependencies; imported by prg_ctrl, prg_dp and the top level.
package prg_pkg;

	localparam int DIGEST_BITS_DEF = 64;
	localparam int DIG_PORT_W      = 64;
	localparam int LEN_W           = 8;
	localparam int CNT_W           = 4;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EXEC
	} prg_state_t;

	typedef enum logic [2:0] {
		MODE_VERIFY      = 3'd0,
		MODE_CHANGE      = 3'd1,
		MODE_RESET_CODE  = 3'd2,
		MODE_RESET_ADMIN = 3'd3,
		MODE_SET_CODE    = 3'd4,
		MODE_CLEAR       = 3'd5
	} prg_mode_t;

	typedef enum logic [1:0] {
		SEL_USER  = 2'd0,
		SEL_ADMIN = 2'd1,
		SEL_CODE  = 2'd2,
		SEL_NONE  = 2'd3
	} prg_sel_t;

	typedef enum logic [2:0] {
		STS_OK      = 3'd0,
		STS_BADLEN  = 3'd1,
		STS_NOCODE  = 3'd2,
		STS_BLOCKED = 3'd3,
		STS_WRONG   = 3'd4
	} prg_status_t;

	typedef enum logic [2:0] {
		CFG_USER_MIN   = 3'd0,
		CFG_ADMIN_MIN  = 3'd1,
		CFG_CODE_MIN   = 3'd2,
		CFG_MAX_LEN    = 3'd3,
		CFG_USER_INIT  = 3'd4,
		CFG_ADMIN_INIT = 3'd5
	} prg_cfg_t;

	// controller -> datapath commands
	typedef struct packed {
		logic load;    // capture the input transfer
		logic fetch;   // look up addressed secret, length checks, digest compare
		logic commit;  // write state and the result register
	} prg_cmd_t;

	function automatic logic len_ok(input logic [LEN_W-1:0] len,
	                                input logic [LEN_W-1:0] mn,
	                                input logic [LEN_W-1:0] mx);
		return (len <= mx) && (len >= mn);
	endfunction

endpackage

// ----- sv/prg_ctrl.sv -----
// Command sequencer for the PIN retry counter guard: idle, fetch, execute.
// Depends on prg_pkg; drives prg_dp through prg_cmd_t.
module prg_ctrl import prg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output prg_cmd_t cmd
);

	prg_state_t state_q, state_n;
	logic       out_valid_q;
	logic       out_free;

	// result register can take a new value this cycle
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_n = ST_FETCH;
			end
			ST_FETCH: begin
				state_n = ST_EXEC;
			end
			ST_EXEC: begin
				if (out_free) state_n = ST_IDLE;
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.load   = (state_q == ST_IDLE) && in_valid;
		cmd.fetch  = (state_q == ST_FETCH);
		cmd.commit = (state_q == ST_EXEC) && out_free;
		in_stall   = (state_q != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(out_valid_q && out_stall))
		else $error("commit while result register held");
	a_accept_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_FETCH))
		else $error("accepted transfer not followed by fetch");
	a_out_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.commit))
		else $error("result appeared without commit");
`endif

endmodule

// ----- sv/prg_dp.sv -----
// Datapath for the PIN retry counter guard: config registers, secret store,
// checks and result register. Depends on prg_pkg; commanded by prg_ctrl.
module prg_dp import prg_pkg::*; #(
	parameter int DIGEST_BITS = DIGEST_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  prg_cmd_t              cmd,
	input  logic [2:0]            mode,
	input  logic [1:0]            which,
	input  logic [DIG_PORT_W-1:0] presented_digest,
	input  logic [LEN_W-1:0]      presented_len,
	input  logic [DIG_PORT_W-1:0] new_digest,
	input  logic [LEN_W-1:0]      new_len,
	output logic [2:0]            status,
	output logic [CNT_W-1:0]      retries_left,
	output logic                  user_verified,
	output logic                  admin_verified,
	output logic                  code_verified,
	output logic                  code_present
);

	// configuration
	logic [LEN_W-1:0] user_min_q, admin_min_q, code_min_q, max_len_q;
	logic [CNT_W-1:0] user_init_q, admin_init_q;

	// secret store: user, admin, reset code
	logic [2:0][DIGEST_BITS-1:0] dig_q, dig_n;
	logic [2:0][CNT_W-1:0]       cnt_q, cnt_n;
	logic [2:0]                  flag_q, flag_n;
	logic                        code_set_q, code_n;

	// captured command
	logic [2:0]             mode_q;
	logic [1:0]             which_q;
	logic [DIGEST_BITS-1:0] pdig_q, ndig_q;
	logic [LEN_W-1:0]       plen_q, nlen_q;

	// fetch stage
	logic [1:0]       tgt_c, nidx_c;
	logic [1:0]       tgt_s1;
	logic             hit_s1, plen_ok_s1, nlen_ok_s1, plen_zero_s1;
	logic [CNT_W-1:0] cnt_s1;

	// execute
	prg_status_t      v_status, sts_n;
	logic             v_upd;
	logic [CNT_W-1:0] v_cnt, retries_n;

	// result register
	logic [2:0]       status_q;
	logic [CNT_W-1:0] retries_q;

	function automatic logic [LEN_W-1:0] min_of(input logic [1:0] idx,
	                                             input logic [LEN_W-1:0] u,
	                                             input logic [LEN_W-1:0] a,
	                                             input logic [LEN_W-1:0] c);
		logic [LEN_W-1:0] r;
		case (idx)
			SEL_USER:  r = u;
			SEL_ADMIN: r = a;
			default:   r = c;
		endcase
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] reload(input logic [1:0] idx,
	                                            input logic [CNT_W-1:0] u,
	                                            input logic [CNT_W-1:0] a);
		return (idx == SEL_USER) ? u : a;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_min_q   <= LEN_W'(6);
			admin_min_q  <= LEN_W'(8);
			code_min_q   <= LEN_W'(8);
			max_len_q    <= LEN_W'(127);
			user_init_q  <= CNT_W'(3);
			admin_init_q <= CNT_W'(3);
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_USER_MIN:   user_min_q   <= cfg_data;
				CFG_ADMIN_MIN:  admin_min_q  <= cfg_data;
				CFG_CODE_MIN:   code_min_q   <= cfg_data;
				CFG_MAX_LEN:    max_len_q    <= cfg_data;
				CFG_USER_INIT:  user_init_q  <= cfg_data[CNT_W-1:0];
				CFG_ADMIN_INIT: admin_init_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			which_q <= which;
			pdig_q  <= presented_digest[DIGEST_BITS-1:0];
			plen_q  <= presented_len;
			ndig_q  <= new_digest[DIGEST_BITS-1:0];
			nlen_q  <= new_len;
		end
	end

	// secret checked/reported, and secret whose new length is checked
	always_comb begin
		case (mode_q)
			MODE_RESET_CODE, MODE_SET_CODE: tgt_c = SEL_CODE;
			MODE_RESET_ADMIN:               tgt_c = SEL_USER;
			default:                        tgt_c = which_q;
		endcase
		nidx_c = (mode_q == MODE_CHANGE) ? tgt_c : SEL_USER;
	end

	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			tgt_s1       <= tgt_c;
			hit_s1       <= (tgt_c != SEL_NONE) && (pdig_q == dig_q[tgt_c]);
			cnt_s1       <= (tgt_c == SEL_NONE) ? '0 : cnt_q[tgt_c];
			plen_ok_s1   <= (tgt_c != SEL_NONE) && len_ok(plen_q,
				min_of(tgt_c, user_min_q, admin_min_q, code_min_q), max_len_q);
			nlen_ok_s1   <= (nidx_c != SEL_NONE) && len_ok(nlen_q,
				min_of(nidx_c, user_min_q, admin_min_q, code_min_q), max_len_q);
			plen_zero_s1 <= (plen_q == '0);
		end
	end

	// verify of the fetched secret
	always_comb begin
		v_upd = 1'b0;
		v_cnt = hit_s1 ? reload(tgt_s1, user_init_q, admin_init_q) : cnt_s1 - CNT_W'(1);
		if ((tgt_s1 == SEL_NONE) || !plen_ok_s1) begin
			v_status = STS_BADLEN;
		end else if ((tgt_s1 == SEL_CODE) && !code_set_q) begin
			v_status = STS_NOCODE;
		end else if (cnt_s1 == '0) begin
			v_status = STS_BLOCKED;
		end else begin
			v_upd = 1'b1;
			if (hit_s1) v_status = STS_OK;
			else if (cnt_s1 == CNT_W'(1)) v_status = STS_BLOCKED;
			else v_status = STS_WRONG;
		end
	end

	always_comb begin
		dig_n  = dig_q;
		cnt_n  = cnt_q;
		flag_n = flag_q;
		code_n = code_set_q;
		sts_n  = STS_WRONG;
		case (mode_q)
			MODE_VERIFY: begin
				sts_n = v_status;
				if (v_upd) begin
					cnt_n[tgt_s1]  = v_cnt;
					flag_n[tgt_s1] = hit_s1;
				end
			end
			MODE_CHANGE: begin
				if (!nlen_ok_s1) begin
					sts_n = STS_BADLEN;
				end else begin
					sts_n = v_status;
					if (v_upd) begin
						cnt_n[tgt_s1]  = v_cnt;
						flag_n[tgt_s1] = hit_s1;
						if (hit_s1) dig_n[tgt_s1] = ndig_q;
					end
				end
			end
			MODE_RESET_CODE: begin
				if (!nlen_ok_s1) begin
					sts_n = STS_BADLEN;
				end else begin
					sts_n = v_status;
					if (v_upd) begin
						cnt_n[SEL_CODE]  = v_cnt;
						flag_n[SEL_CODE] = hit_s1;
						if (hit_s1) begin
							dig_n[SEL_USER]  = ndig_q;
							cnt_n[SEL_USER]  = user_init_q;
							flag_n[SEL_USER] = 1'b0;
						end
					end
				end
			end
			MODE_RESET_ADMIN: begin
				if (!nlen_ok_s1) begin
					sts_n = STS_BADLEN;
				end else if (!flag_q[SEL_ADMIN]) begin
					sts_n = STS_WRONG;
				end else begin
					dig_n[SEL_USER]  = ndig_q;
					cnt_n[SEL_USER]  = user_init_q;
					flag_n[SEL_USER] = 1'b0;
					sts_n = STS_OK;
				end
			end
			MODE_SET_CODE: begin
				if (!flag_q[SEL_ADMIN]) begin
					sts_n = STS_WRONG;
				end else if (plen_zero_s1) begin
					dig_n[SEL_CODE] = '0;
					cnt_n[SEL_CODE] = '0;
					code_n = 1'b0;
					sts_n  = STS_OK;
				end else if (!plen_ok_s1) begin
					sts_n = STS_BADLEN;
				end else begin
					dig_n[SEL_CODE] = pdig_q;
					cnt_n[SEL_CODE] = admin_init_q;
					code_n = 1'b1;
					sts_n  = STS_OK;
				end
			end
			MODE_CLEAR: begin
				flag_n = '0;
				sts_n  = STS_OK;
			end
			default: begin
				sts_n = STS_WRONG;
			end
		endcase
		retries_n = (tgt_s1 == SEL_NONE) ? '0 : cnt_n[tgt_s1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_q      <= '0;
			cnt_q      <= {CNT_W'(0), CNT_W'(3), CNT_W'(3)};
			flag_q     <= '0;
			code_set_q <= 1'b0;
		end else if (cmd.commit) begin
			dig_q      <= dig_n;
			cnt_q      <= cnt_n;
			flag_q     <= flag_n;
			code_set_q <= code_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q  <= sts_n;
			retries_q <= retries_n;
		end
	end

	// flags change only at commit, which waits for the result register to drain
	assign status         = status_q;
	assign retries_left   = retries_q;
	assign user_verified  = flag_q[SEL_USER];
	assign admin_verified = flag_q[SEL_ADMIN];
	assign code_verified  = flag_q[SEL_CODE];
	assign code_present   = code_set_q;

`ifndef SYNTHESIS
	a_code_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		!code_set_q |-> (cnt_q[SEL_CODE] == '0))
		else $error("reset code counter nonzero while code unset");
	a_clear_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && (mode_q == MODE_CLEAR)) |=> (flag_q == '0))
		else $error("session clear left a flag set");
	a_bad_sel: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && (tgt_s1 == SEL_NONE)) |=> ($stable(cnt_q) && $stable(dig_q)))
		else $error("invalid secret select changed the store");
`endif

endmodule

// ----- sv/pin_retry_counter_guard_core.sv -----
// Top level of the PIN retry counter guard: controller plus datapath.
// Depends on prg_pkg, prg_ctrl and prg_dp.
//
// Guards the user PIN, admin PIN and reset code. Each command (verify,
// change, reset user PIN via reset code or via a verified admin PIN, set or
// clear the reset code, clear session) arrives as one input transfer with
// already hashed digests, of which the low DIGEST_BITS bits are stored and
// compared, and gives exactly one result transfer: a status code, the retry
// counter of the addressed secret after the command, the three session flags
// and whether a reset code is set. A command runs through capture,
// fetch (secret lookup, length checks, digest compare into a register) and
// commit (state and result register written). The next command is accepted
// once the block is back in idle, even while the previous result still waits
// downstream; its commit then waits until that result has been taken.
// Configuration registers (minimum lengths, maximum length, retry reload
// values) must be written through cfg_we/cfg_idx/cfg_data only while no
// command is in flight, which the block itself does not enforce; they take
// effect for the next command. No clearing pass after reset: the store is
// three entries of flip-flops and resets at once.
module pin_retry_counter_guard_core import prg_pkg::*; #(
	parameter int DIGEST_BITS = DIGEST_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// command channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [2:0]            mode,
	input  logic [1:0]            which,
	input  logic [DIG_PORT_W-1:0] presented_digest,
	input  logic [LEN_W-1:0]      presented_len,
	input  logic [DIG_PORT_W-1:0] new_digest,
	input  logic [LEN_W-1:0]      new_len,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            status,
	output logic [CNT_W-1:0]      retries_left,
	output logic                  user_verified,
	output logic                  admin_verified,
	output logic                  code_verified,
	output logic                  code_present
);

	prg_cmd_t cmd;

	// sequencer: one command in flight, result register decouples output
	prg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// config, secret store, checks and result register
	prg_dp #(
		.DIGEST_BITS (DIGEST_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_idx          (cfg_idx),
		.cfg_data         (cfg_data),
		.cmd              (cmd),
		.mode             (mode),
		.which            (which),
		.presented_digest (presented_digest),
		.presented_len    (presented_len),
		.new_digest       (new_digest),
		.new_len          (new_len),
		.status           (status),
		.retries_left     (retries_left),
		.user_verified    (user_verified),
		.admin_verified   (admin_verified),
		.code_verified    (code_verified),
		.code_present     (code_present)
	);

endmodule

// ----- test/tb_top.sv -----
// Self-checking bench for pin_retry_counter_guard_core: a short table of commands, then
// constrained-by-hand random commands under six register settings, checked by a predictor.
// Depends on prg_pkg and the core RTL.
module tb_top;
	import prg_pkg::*;

	// opcodes the package leaves undefined; the guard must answer them with STS_WRONG
	localparam logic [2:0] MODE_UNDEF_A = 3'd6;
	localparam logic [2:0] MODE_UNDEF_B = 3'd7;

	localparam logic [63:0] DIG_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] CODE_A   = 64'hA5A5_A5A5_A5A5_A5A5;
	localparam logic [63:0] CODE_B   = 64'h5A5A_5A5A_5A5A_5A5A;
	localparam logic [63:0] USER_B   = 64'h0123_4567_89AB_CDEF;
	localparam logic [63:0] USER_C   = 64'hFEDC_BA98_7654_3210;

	localparam int N_DIRECTED    = 28;
	localparam int N_PHASES      = 6;
	localparam int CMDS_PER_PHASE = 100;
	localparam int LONG_HOLD     = 40;

	typedef struct packed {
		logic [2:0]  mode;
		logic [1:0]  which;
		logic [63:0] pdig;
		logic [7:0]  plen;
		logic [63:0] ndig;
		logic [7:0]  nlen;
	} guard_cmd_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] retries;
		logic       user_ok;
		logic       admin_ok;
		logic       code_ok;
		logic       code_set;
	} guard_result_t;

	// one row of the directed table; pinned rows carry a hand-typed status and counter
	typedef struct packed {
		guard_cmd_t  cmd;
		logic        pinned;
		prg_status_t status;
		logic [3:0]  retries;
	} probe_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [2:0]            mode = '0;
	logic [1:0]            which = '0;
	logic [DIG_PORT_W-1:0] presented_digest = '0;
	logic [LEN_W-1:0]      presented_len = '0;
	logic [DIG_PORT_W-1:0] new_digest = '0;
	logic [LEN_W-1:0]      new_len = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [2:0]            status;
	logic [CNT_W-1:0]      retries_left;
	logic                  user_verified;
	logic                  admin_verified;
	logic                  code_verified;
	logic                  code_present;

	// predictor copy of the guarded secrets, indexed by prg_sel_t
	logic [63:0] dig_q [3];
	logic [7:0]  len_q [3];
	logic [3:0]  cnt_q [3];
	logic        ok_q [3];
	logic        code_set_q;
	// predictor copy of the registers
	logic [7:0]  min_len [3];
	logic [7:0]  len_ceiling;
	logic [3:0]  init_user;
	logic [3:0]  init_admin;

	guard_result_t results_due [$];

	// shared knobs between the command thread and the result sink
	bit gaps_on = 1'b1;
	bit hold_off_req = 1'b0;

	int error_count = 0;
	int cmds_sent = 0;
	int results_checked = 0;
	int settings_used = 1;

	pin_retry_counter_guard_core i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_idx          (cfg_idx),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.mode             (mode),
		.which            (which),
		.presented_digest (presented_digest),
		.presented_len    (presented_len),
		.new_digest       (new_digest),
		.new_len          (new_len),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.retries_left     (retries_left),
		.user_verified    (user_verified),
		.admin_verified   (admin_verified),
		.code_verified    (code_verified),
		.code_present     (code_present)
	);

	always #10 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic bit len_fits(int idx, logic [7:0] l);
		if (idx > 2) return 1'b0;
		return (l <= len_ceiling) && (l >= min_len[idx]);
	endfunction

	function automatic logic [3:0] reload_of(int idx);
		return (idx == SEL_USER) ? init_user : init_admin;
	endfunction

	// length, presence and blocked checks, then the digest compare:
	// a match reloads the counter and sets the session flag, a miss burns one try
	function automatic prg_status_t check_secret(int idx, logic [63:0] d, logic [7:0] l);
		if (!len_fits(idx, l)) return STS_BADLEN;
		if (idx == SEL_CODE && !code_set_q) return STS_NOCODE;
		if (cnt_q[idx] == 4'd0) return STS_BLOCKED;
		if (d == dig_q[idx]) begin
			cnt_q[idx] = reload_of(idx);
			ok_q[idx] = 1'b1;
			return STS_OK;
		end
		ok_q[idx] = 1'b0;
		cnt_q[idx] = cnt_q[idx] - 4'd1;
		return (cnt_q[idx] == 4'd0) ? STS_BLOCKED : STS_WRONG;
	endfunction

	function automatic void store_user_pin(logic [63:0] d, logic [7:0] l);
		dig_q[SEL_USER] = d;
		len_q[SEL_USER] = l;
		cnt_q[SEL_USER] = reload_of(SEL_USER);
		ok_q[SEL_USER] = 1'b0;
	endfunction

	// executes one command on the predictor state and returns the result it should produce
	function automatic guard_result_t apply_command(guard_cmd_t c);
		guard_result_t r;
		prg_status_t st;
		int shown;
		shown = c.which;
		st = STS_WRONG;
		case (c.mode)
			MODE_VERIFY: begin
				st = (c.which == SEL_NONE) ? STS_BADLEN : check_secret(c.which, c.pdig, c.plen);
			end
			MODE_CHANGE: begin
				if (c.which == SEL_NONE || !len_fits(c.which, c.nlen)) begin
					st = STS_BADLEN;
				end else begin
					st = check_secret(c.which, c.pdig, c.plen);
					if (st == STS_OK) begin
						dig_q[c.which] = c.ndig;
						len_q[c.which] = c.nlen;
					end
				end
			end
			MODE_RESET_CODE: begin
				shown = SEL_CODE;
				if (!len_fits(SEL_USER, c.nlen)) begin
					st = STS_BADLEN;
				end else begin
					st = check_secret(SEL_CODE, c.pdig, c.plen);
					if (st == STS_OK) store_user_pin(c.ndig, c.nlen);
				end
			end
			MODE_RESET_ADMIN: begin
				shown = SEL_USER;
				if (!len_fits(SEL_USER, c.nlen)) begin
					st = STS_BADLEN;
				end else if (!ok_q[SEL_ADMIN]) begin
					st = STS_WRONG;
				end else begin
					store_user_pin(c.ndig, c.nlen);
					st = STS_OK;
				end
			end
			MODE_SET_CODE: begin
				shown = SEL_CODE;
				if (!ok_q[SEL_ADMIN]) begin
					st = STS_WRONG;
				end else if (c.plen == 8'd0) begin
					// zero length removes the reset code altogether
					dig_q[SEL_CODE] = '0;
					len_q[SEL_CODE] = '0;
					cnt_q[SEL_CODE] = '0;
					code_set_q = 1'b0;
					st = STS_OK;
				end else if (!len_fits(SEL_CODE, c.plen)) begin
					st = STS_BADLEN;
				end else begin
					dig_q[SEL_CODE] = c.pdig;
					len_q[SEL_CODE] = c.plen;
					cnt_q[SEL_CODE] = reload_of(SEL_CODE);
					code_set_q = 1'b1;
					st = STS_OK;
				end
			end
			MODE_CLEAR: begin
				ok_q = '{default: 1'b0};
				st = STS_OK;
			end
			default: st = STS_WRONG;
		endcase
		r.status = st;
		r.retries = (shown <= 2) ? cnt_q[shown] : 4'd0;
		r.user_ok = ok_q[SEL_USER];
		r.admin_ok = ok_q[SEL_ADMIN];
		r.code_ok = ok_q[SEL_CODE];
		r.code_set = code_set_q;
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus

	// mostly a length the addressed secret accepts, sometimes anything
	function automatic logic [7:0] pick_len(int idx);
		if (idx <= 2 && min_len[idx] <= len_ceiling && $urandom_range(99, 0) < 85)
			return 8'($urandom_range(len_ceiling, min_len[idx]));
		return 8'($urandom_range(255, 0));
	endfunction

	// Random command, biased toward sequences that get past the checks: the stored
	// digest is presented more often than not. The admin PIN is never allowed to
	// burn its last try, since nothing but reset restores it; blocking it is left
	// to the zero-reload phase at the end.
	function automatic guard_cmd_t make_command();
		guard_cmd_t c;
		int unsigned roll;
		int tgt;
		roll = $urandom_range(99, 0);
		if (roll < 35) c.mode = MODE_VERIFY;
		else if (roll < 50) c.mode = MODE_CHANGE;
		else if (roll < 60) c.mode = MODE_RESET_CODE;
		else if (roll < 70) c.mode = MODE_RESET_ADMIN;
		else if (roll < 84) c.mode = MODE_SET_CODE;
		else if (roll < 93) c.mode = MODE_CLEAR;
		else c.mode = $urandom_range(1, 0) ? MODE_UNDEF_A : MODE_UNDEF_B;
		c.which = ($urandom_range(19, 0) == 0) ? 2'(SEL_NONE) : 2'($urandom_range(2, 0));
		tgt = (c.mode == MODE_RESET_CODE || c.mode == MODE_SET_CODE) ? int'(SEL_CODE) : c.which;
		c.pdig = {$urandom, $urandom};
		if (tgt <= 2 && ($urandom_range(99, 0) < 60 ||
				(tgt == SEL_ADMIN && cnt_q[SEL_ADMIN] <= 4'd1)))
			c.pdig = dig_q[tgt];
		c.plen = pick_len(tgt);
		if (c.mode == MODE_SET_CODE && $urandom_range(9, 0) == 0) c.plen = 8'd0;
		c.ndig = {$urandom, $urandom};
		c.nlen = pick_len((c.mode == MODE_CHANGE) ? int'(c.which) : int'(SEL_USER));
		return c;
	endfunction

	// Offers one command, holds it until the transfer, then books its result.
	// Called at a rising edge; in_valid sees a single update per time step.
	task automatic send_command(guard_cmd_t c, bit pinned, prg_status_t pin_st,
			logic [3:0] pin_rl);
		int unsigned gap;
		guard_result_t r;
		gap = gaps_on ? $urandom_range(4, 0) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= c.mode;
		which <= c.which;
		presented_digest <= c.pdig;
		presented_len <= c.plen;
		new_digest <= c.ndig;
		new_len <= c.nlen;
		do @(posedge clk); while (in_stall);
		r = apply_command(c);
		if (pinned) begin
			r.status = pin_st;
			r.retries = pin_rl;
		end
		results_due.push_back(r);
		cmds_sent++;
	endtask

	// stop offering and let every booked result drain, then wait on until the
	// block is surely back in idle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// writes all six registers back to back, one per edge, only while idle
	task automatic program_registers(logic [7:0] u_min, logic [7:0] a_min, logic [7:0] c_min,
			logic [7:0] mx, logic [7:0] u_init, logic [7:0] a_init);
		logic [7:0] vals [6];
		prg_cfg_t sel;
		vals[CFG_USER_MIN] = u_min;
		vals[CFG_ADMIN_MIN] = a_min;
		vals[CFG_CODE_MIN] = c_min;
		vals[CFG_MAX_LEN] = mx;
		vals[CFG_USER_INIT] = u_init;
		vals[CFG_ADMIN_INIT] = a_init;
		for (int i = 0; i < 6; i++) begin
			sel = prg_cfg_t'(i);
			cfg_we <= 1'b1;
			cfg_idx <= sel;
			cfg_data <= vals[i];
			@(posedge clk);
			case (sel)
				CFG_USER_MIN:   min_len[SEL_USER] = vals[i];
				CFG_ADMIN_MIN:  min_len[SEL_ADMIN] = vals[i];
				CFG_CODE_MIN:   min_len[SEL_CODE] = vals[i];
				CFG_MAX_LEN:    len_ceiling = vals[i];
				CFG_USER_INIT:  init_user = vals[i][3:0];
				CFG_ADMIN_INIT: init_admin = vals[i][3:0];
				default: ;
			endcase
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		if (error_count < 40)
			$display("MISMATCH result %0d %s: got %0d expected %0d", results_checked, what,
				got, want);
		error_count++;
	endtask

	// result sink: per transfer draws a random stall while gaps are on, or one long hold on request
	initial begin : result_sink
		int unsigned hold;
		forever begin
			if (hold_off_req) begin
				hold = LONG_HOLD;
				hold_off_req = 1'b0;
			end else begin
				hold = gaps_on ? $urandom_range(4, 0) : 0;
			end
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	// every result transfer is compared field by field with the oldest booked result
	always @(posedge clk) begin : result_check
		guard_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				report_mismatch("unexpected transfer", status, 0);
			end else begin
				want = results_due.pop_front();
				if (status !== want.status) report_mismatch("status", status, want.status);
				if (retries_left !== want.retries)
					report_mismatch("retries_left", retries_left, want.retries);
				if (user_verified !== want.user_ok)
					report_mismatch("user_verified", user_verified, want.user_ok);
				if (admin_verified !== want.admin_ok)
					report_mismatch("admin_verified", admin_verified, want.admin_ok);
				if (code_verified !== want.code_ok)
					report_mismatch("code_verified", code_verified, want.code_ok);
				if (code_present !== want.code_set)
					report_mismatch("code_present", code_present, want.code_set);
			end
			results_checked++;
		end
	end

	// ---------------------------------------------------------------- directed table

	// Starts from the reset state: all digests zero, counters 3/3/0, no reset code,
	// registers at 6/8/8/127/3/3. Pinned rows carry the obvious answer; the rest
	// (successful changes and resets, clear session, the burn-down of the user PIN)
	// are left to the predictor.
	probe_row_t directed_rows [N_DIRECTED] = '{
		// invalid selector, unset code, user length below min, user match
		'{'{MODE_VERIFY, SEL_NONE, 64'd0, 8'd6, 64'd0, 8'd0}, 1'b1, STS_BADLEN, 4'd0},
		'{'{MODE_VERIFY, SEL_CODE, 64'd0, 8'd8, 64'd0, 8'd0}, 1'b1, STS_NOCODE, 4'd0},
		'{'{MODE_VERIFY, SEL_USER, 64'd0, 8'd5, 64'd0, 8'd0}, 1'b1, STS_BADLEN, 4'd3},
		'{'{MODE_VERIFY, SEL_USER, 64'd0, 8'd6, 64'd0, 8'd0}, 1'b1, STS_OK, 4'd3},
		// admin: over max length, a miss, then a match that reloads the counter
		'{'{MODE_VERIFY, SEL_ADMIN, DIG_ONES, 8'd255, DIG_ONES, 8'd255}, 1'b1, STS_BADLEN, 4'd3},
		'{'{MODE_VERIFY, SEL_ADMIN, DIG_ONES, 8'd8, 64'd0, 8'd0}, 1'b1, STS_WRONG, 4'd2},
		'{'{MODE_VERIFY, SEL_ADMIN, 64'd0, 8'd127, 64'd0, 8'd0}, 1'b1, STS_OK, 4'd3},
		// reset code: set, miss, match, clear with zero length, too long, set again
		'{'{MODE_SET_CODE, SEL_USER, CODE_A, 8'd8, 64'd0, 8'd0}, 1'b1, STS_OK, 4'd3},
		'{'{MODE_VERIFY, SEL_CODE, 64'd0, 8'd8, 64'd0, 8'd0}, 1'b1, STS_WRONG, 4'd2},
		'{'{MODE_VERIFY, SEL_CODE, CODE_A, 8'd8, 64'd0, 8'd0}, 1'b1, STS_OK, 4'd3},
		'{'{MODE_SET_CODE, SEL_CODE, CODE_A, 8'd0, 64'd0, 8'd0}, 1'b1, STS_OK, 4'd0},
		'{'{MODE_SET_CODE, SEL_CODE, CODE_B, 8'd200, 64'd0, 8'd0}, 1'b1, STS_BADLEN, 4'd0},
		'{'{MODE_SET_CODE, SEL_CODE, CODE_B, 8'd16, 64'd0, 8'd0}, 1'b0, STS_OK, 4'd0},
		// change: invalid selector, new length too long, then a good change
		'{'{MODE_CHANGE, SEL_NONE, 64'd0, 8'd6, DIG_ONES, 8'd6}, 1'b1, STS_BADLEN, 4'd0},
		'{'{MODE_CHANGE, SEL_USER, 64'd0, 8'd6, DIG_ONES, 8'd255}, 1'b1, STS_BADLEN, 4'd3},
		'{'{MODE_CHANGE, SEL_USER, 64'd0, 8'd6, DIG_ONES, 8'd6}, 1'b0, STS_OK, 4'd0},
		// user PIN reset through the admin PIN and through the reset code, then a too-short new PIN
		'{'{MODE_RESET_ADMIN, SEL_USER, 64'd0, 8'd0, USER_B, 8'd10}, 1'b0, STS_OK, 4'd0},
		'{'{MODE_RESET_CODE, SEL_CODE, CODE_B, 8'd16, USER_C, 8'd6}, 1'b0, STS_OK, 4'd0},
		'{'{MODE_RESET_CODE, SEL_CODE, CODE_B, 8'd16, USER_C, 8'd2}, 1'b1, STS_BADLEN, 4'd3},
		// undefined opcodes
		'{'{MODE_UNDEF_A, SEL_ADMIN, DIG_ONES, 8'd255, DIG_ONES, 8'd255}, 1'b1, STS_WRONG, 4'd3},
		'{'{MODE_UNDEF_B, SEL_NONE, 64'd0, 8'd0, 64'd0, 8'd0}, 1'b1, STS_WRONG, 4'd0},
		// drop the session, after which admin-only commands are refused
		'{'{MODE_CLEAR, SEL_USER, 64'd0, 8'd0, 64'd0, 8'd0}, 1'b0, STS_OK, 4'd0},
		'{'{MODE_RESET_ADMIN, SEL_USER, 64'd0, 8'd0, USER_B, 8'd8}, 1'b1, STS_WRONG, 4'd3},
		'{'{MODE_SET_CODE, SEL_CODE, CODE_A, 8'd8, 64'd0, 8'd0}, 1'b1, STS_WRONG, 4'd3},
		// burn the user PIN down to blocked; a correct PIN no longer helps
		'{'{MODE_VERIFY, SEL_USER, DIG_ONES, 8'd6, 64'd0, 8'd0}, 1'b0, STS_OK, 4'd0},
		'{'{MODE_VERIFY, SEL_USER, DIG_ONES, 8'd6, 64'd0, 8'd0}, 1'b0, STS_OK, 4'd0},
		'{'{MODE_VERIFY, SEL_USER, DIG_ONES, 8'd6, 64'd0, 8'd0}, 1'b0, STS_OK, 4'd0},
		'{'{MODE_VERIFY, SEL_USER, USER_C, 8'd6, 64'd0, 8'd0}, 1'b1, STS_BLOCKED, 4'd0}
	};

	// ---------------------------------------------------------------- sequence

	initial begin : command_flow
		dig_q = '{default: '0};
		len_q = '{default: '0};
		ok_q = '{default: 1'b0};
		cnt_q[SEL_USER] = 4'd3;
		cnt_q[SEL_ADMIN] = 4'd3;
		cnt_q[SEL_CODE] = 4'd0;
		code_set_q = 1'b0;
		min_len[SEL_USER] = 8'd6;
		min_len[SEL_ADMIN] = 8'd8;
		min_len[SEL_CODE] = 8'd8;
		len_ceiling = 8'd127;
		init_user = 4'd3;
		init_admin = 4'd3;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_command(directed_rows[i].cmd, directed_rows[i].pinned,
				directed_rows[i].status, directed_rows[i].retries);
		wait_idle();

		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				// everything open: zero lengths allowed, full counters
				0: program_registers(8'd0, 8'd0, 8'd0, 8'd255, 8'd15, 8'd15);
				// only length 255 passes; one try per secret
				1: program_registers(8'd255, 8'd255, 8'd255, 8'd255, 8'd1, 8'd1);
				2: program_registers(8'd4, 8'd6, 8'd5, 8'd12, 8'd9, 8'd2);
				// max length zero: only empty secrets, so no code can be set
				3: program_registers(8'd0, 8'd0, 8'd0, 8'd0, 8'd7, 8'd3);
				// random lengths; upper nibble of the reload registers is junk
				4: program_registers(8'($urandom_range(16, 0)), 8'($urandom_range(16, 0)),
					8'($urandom_range(16, 0)), 8'($urandom_range(255, 16)),
					{4'($urandom), 4'($urandom_range(15, 1))},
					{4'($urandom), 4'($urandom_range(15, 1))});
				// zero reload: a match leaves the counter at zero and blocks it;
				// kept last because the admin PIN ends up blocked for good
				default: program_registers(8'd3, 8'd3, 8'd3, 8'd40, 8'd0, 8'd0);
			endcase
			gaps_on = (p != 1);
			for (int n = 0; n < CMDS_PER_PHASE; n++) begin
				// sink holds off while commands keep coming, so in_stall must rise
				if (p == 1 && n == 30) hold_off_req = 1'b1;
				// idle stretch on one side, then a full drain mid-phase
				if (p == 2 && n == 50) wait_idle();
				if (p == 3) gaps_on = (n >= 50);
				send_command(make_command(), 1'b0, STS_OK, 4'd0);
			end
			wait_idle();
		end

		if (results_due.size() != 0)
			report_mismatch("results never delivered", results_due.size(), 0);
		$display("Ran %0d commands (%0d from the table) under %0d register settings;",
			cmds_sent, N_DIRECTED, settings_used);
		$display("%0d result transfers compared, %0d mismatches.", results_checked,
			error_count);
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// hard stop, far beyond the slowest legal run
	initial begin : watchdog
		#4000000;
		$display("Verification failed");
		$finish;
	end

endmodule
